// File: hdl/ccm_pkg.sv
// Package for the CBC-MAC tag block: payload structs, opcodes, phase enum,
// front-to-back command struct and the AES S-box and xtime helpers.
// No dependencies.
package ccm_pkg;

  localparam int MaxTotalLength = 127;
  localparam logic [7:0] HdrFlags = 8'h49;

  localparam logic OpStart = 1'b0;
  localparam logic OpData  = 1'b1;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusLength = 2'd1;
  localparam logic [1:0] StatusTagLen = 2'd2;

  localparam logic [1:0] CfgKeyHigh = 2'd0;
  localparam logic [1:0] CfgKeyLow  = 2'd1;
  localparam logic [1:0] CfgTagLen  = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [63:0] source_address;
    logic [39:0] slot_number;
    logic [6:0]  auth_length;
    logic [6:0]  message_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] tag_high;
    logic [63:0] tag_low;
  } out_item_t;

  typedef enum logic [1:0] {PH_IDLE, PH_AUTH, PH_MSG} phase_t;

  // Command from the front end to the back end.  The front end packs bytes
  // into 16-byte blocks; the back end absorbs blocks and emits results.
  typedef enum logic [1:0] {CMD_CLEAR, CMD_BLOCK, CMD_EMIT} cmd_op_t;

  typedef struct packed {
    cmd_op_t      op;
    logic [127:0] blk;    // block to absorb (CMD_BLOCK)
    logic         last;   // emit a tag after this block
    logic [1:0]   status; // status for CMD_EMIT without block
  } cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic tag_len_ok(input logic [4:0] tl);
    return (tl == 5'd4) || (tl == 5'd8) || (tl == 5'd16);
  endfunction

endpackage

// File: hdl/ccm_star_cbc_mac_tag.sv
// Top level of the AES-128 CBC-MAC tag block.  Depends on ccm_pkg,
// ccm_front, ccm_queue and ccm_back.
//
// A data beat is taken every cycle while the command queue has room and no
// start command is pending; a valid start beat yields a clear, the header
// block and, when no auth bytes follow, a padded second block. Each completed
// 16-byte block runs through the AES unit one round per cycle, so over a frame
// the block keeps up with one byte per cycle; bursts of padded short blocks
// stall the input through the four-entry queue. The tag leaves through an output
// register, so the next frame's bytes are taken while it waits.
module ccm_star_cbc_mac_tag import ccm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  logic [63:0] key_high_r, key_low_r;
  logic [4:0]  tag_len_r;
  logic        f_valid, f_stall, q_valid, q_take;
  cmd_t        f_cmd, q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      tag_len_r  <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgKeyHigh: key_high_r <= cfg_data;
        CfgKeyLow:  key_low_r  <= cfg_data;
        CfgTagLen:  tag_len_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  ccm_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .tag_len(tag_len_r), .cmd_valid(f_valid), .cmd_stall(f_stall), .cmd(f_cmd)
  );

  ccm_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_cmd)
  );

  ccm_back u_back (
    .clk, .rst_n, .key_high(key_high_r), .key_low(key_low_r), .tag_len(tag_len_r),
    .cmd_valid(q_valid), .cmd_take(q_take), .cmd(q_cmd),
    .out_valid, .out_stall, .out_data
  );

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_ok_tag_len: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && out_data.status == StatusOk |-> tag_len_ok(tag_len_r))
    else $error("tag given under a bad tag length");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != StatusOk |->
      out_data.tag_high == '0 && out_data.tag_low == '0)
    else $error("error result carries tag bytes");

endmodule

// File: hdl/ccm_front.sv
// Front end: takes input beats, tracks frame phase and packs bytes into
// 16-byte blocks, handing block, clear and emit commands to the queue.
// Depends on ccm_pkg.
module ccm_front import ccm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  input  logic [4:0] tag_len,
  output logic       cmd_valid,
  input  logic       cmd_stall,
  output cmd_t       cmd
);

  phase_t       phase_r, phase_nxt;
  logic [6:0]   auth_left_r, auth_left_nxt;
  logic [6:0]   msg_left_r, msg_left_nxt;
  logic [3:0]   pos_r, pos_nxt;
  logic [119:0] buf_r, buf_nxt;     // first 15 bytes of the open block
  // A start beat produces up to three commands (clear, header block, then
  // a partial second block); the pending ones wait here.
  logic         pend_hdr_r, pend_hdr_nxt;
  logic [127:0] hdr_r, hdr_nxt;
  logic         pend_b2_r, pend_b2_nxt;
  logic         accept;
  logic [7:0]   byte_in;
  logic [127:0] full_blk;
  logic         part_end, msg_end;
  logic [6:0]   left_dec;

  assign in_stall = cmd_stall || pend_hdr_r || pend_b2_r;
  assign accept   = in_valid && !in_stall;
  assign byte_in  = in_data.data_byte;
  assign full_blk = {buf_r, byte_in};

  always_comb begin
    phase_nxt     = phase_r;
    auth_left_nxt = auth_left_r;
    msg_left_nxt  = msg_left_r;
    pos_nxt       = pos_r;
    buf_nxt       = buf_r;
    pend_hdr_nxt  = pend_hdr_r;
    hdr_nxt       = hdr_r;
    pend_b2_nxt   = pend_b2_r;
    cmd_valid     = 1'b0;
    cmd           = '{op: CMD_BLOCK, blk: full_blk, last: 1'b0, status: StatusOk};
    part_end      = 1'b0;
    msg_end       = 1'b0;
    left_dec      = '0;
    if (pend_hdr_r) begin
      cmd_valid = 1'b1;
      cmd.blk   = hdr_r;
      if (!cmd_stall) pend_hdr_nxt = 1'b0;
    end else if (pend_b2_r) begin
      // Second part closes with no auth bytes: pad it out.
      cmd_valid = 1'b1;
      cmd.blk   = {buf_r[119:104], 112'd0};
      cmd.last  = (msg_left_r == '0);
      if (!cmd_stall) begin
        pend_b2_nxt = 1'b0;
        pos_nxt     = '0;
        phase_nxt   = (msg_left_r == '0) ? PH_IDLE : PH_MSG;
      end
    end else if (accept) begin
      if (in_data.operation == OpStart) begin
        phase_nxt = PH_IDLE;
        cmd_valid = 1'b1;
        if (!tag_len_ok(tag_len)) begin
          cmd = '{op: CMD_EMIT, blk: '0, last: 1'b0, status: StatusTagLen};
        end else if ({1'b0, in_data.auth_length} + {1'b0, in_data.message_length}
                     > 8'(MaxTotalLength)) begin
          cmd = '{op: CMD_EMIT, blk: '0, last: 1'b0, status: StatusLength};
        end else begin
          cmd          = '{op: CMD_CLEAR, blk: '0, last: 1'b0, status: StatusOk};
          pend_hdr_nxt = 1'b1;
          hdr_nxt      = {8'd0, 1'b0, in_data.message_length, in_data.slot_number,
                          in_data.source_address, HdrFlags};
          auth_left_nxt = in_data.auth_length;
          msg_left_nxt  = in_data.message_length;
          buf_nxt       = {8'd0, 1'b0, in_data.auth_length, 104'd0};
          pos_nxt       = 4'd2;
          phase_nxt     = PH_AUTH;
          // Empty auth part still pads a whole block, even for an empty frame.
          if (in_data.auth_length == '0) pend_b2_nxt = 1'b1;
        end
      end else if (phase_r == PH_AUTH || phase_r == PH_MSG) begin
        if (phase_r == PH_AUTH) begin
          left_dec      = auth_left_r - 7'd1;
          auth_left_nxt = left_dec;
        end else begin
          left_dec     = msg_left_r - 7'd1;
          msg_left_nxt = left_dec;
        end
        part_end = (left_dec == '0);
        msg_end  = part_end && (phase_r == PH_MSG || msg_left_r == '0);
        if (pos_r == 4'd15 || part_end) begin
          cmd_valid = 1'b1;
          for (int i = 0; i < 16; i++) begin
            if (4'(i) < pos_r) cmd.blk[127-8*i -: 8] = buf_r[119-8*i -: 8];
            else if (4'(i) == pos_r) cmd.blk[127-8*i -: 8] = byte_in;
            else cmd.blk[127-8*i -: 8] = 8'd0;
          end
          cmd.last = msg_end;
          pos_nxt  = '0;
        end else begin
          buf_nxt[119-8*pos_r -: 8] = byte_in;
          pos_nxt = pos_r + 4'd1;
        end
        if (part_end) phase_nxt = msg_end ? PH_IDLE : PH_MSG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      auth_left_r <= '0;
      msg_left_r  <= '0;
      pos_r       <= '0;
      pend_hdr_r  <= 1'b0;
      pend_b2_r   <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      auth_left_r <= auth_left_nxt;
      msg_left_r  <= msg_left_nxt;
      pos_r       <= pos_nxt;
      pend_hdr_r  <= pend_hdr_nxt;
      pend_b2_r   <= pend_b2_nxt;
    end
    buf_r <= buf_nxt;
    hdr_r <= hdr_nxt;
  end

endmodule

// File: hdl/ccm_queue.sv
// Short command queue between front and back end.
// Depends on ccm_pkg.
module ccm_queue import ccm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_stall,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_take,
  output cmd_t rd_data
);

  localparam int Depth = 4;
  cmd_t       mem_r [Depth];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       wr, rd;

  assign wr_stall = (cnt_r == 3'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr       = wr_valid && !wr_stall;
  assign rd       = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr) - 3'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end

endmodule

// File: hdl/ccm_back.sv
// Back end: iterative AES-128 over the CBC chain, one round per cycle unless
// a tag waits for the result register, plus that register.  Depends on ccm_pkg.
module ccm_back import ccm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [63:0] key_high,
  input  logic [63:0] key_low,
  input  logic [4:0] tag_len,
  input  logic       cmd_valid,
  output logic       cmd_take,
  input  cmd_t       cmd,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  logic [127:0] chain_r, chain_nxt;
  logic [127:0] st_r, st_nxt;
  logic [127:0] rk_r, rk_nxt;
  logic [7:0]   rcon_r, rcon_nxt;
  logic [3:0]   round_r, round_nxt;
  logic         busy_r, busy_nxt;
  logic         last_r, last_nxt;
  logic         ov_r, ov_nxt;
  out_item_t    od_r, od_nxt;
  logic [127:0] sb, mc, rk_next;
  logic [31:0]  t;
  logic [7:0]   a0, a1, a2, a3, all;
  logic         out_free;

  assign out_free = !ov_r || !out_stall;
  // An emit command needs the output register, so it is taken only when that
  // register is free; any head command is taken only when nothing is in flight.
  assign cmd_take = cmd_valid && !busy_r &&
                    !(cmd.op == CMD_EMIT && !out_free);

  always_comb begin
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        sb[127-8*(4*c+r) -: 8] = SBOX[st_r[127-8*(4*((c+r)%4)+r) -: 8]];
    mc = sb;
    for (int c = 0; c < 4; c++) begin
      a0 = sb[127-32*c -: 8];
      a1 = sb[119-32*c -: 8];
      a2 = sb[111-32*c -: 8];
      a3 = sb[103-32*c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      mc[127-32*c -: 8] = a0 ^ all ^ xt(a0 ^ a1);
      mc[119-32*c -: 8] = a1 ^ all ^ xt(a1 ^ a2);
      mc[111-32*c -: 8] = a2 ^ all ^ xt(a2 ^ a3);
      mc[103-32*c -: 8] = a3 ^ all ^ xt(a3 ^ a0);
    end
    t = {SBOX[rk_r[23:16]] ^ rcon_r, SBOX[rk_r[15:8]], SBOX[rk_r[7:0]], SBOX[rk_r[31:24]]};
    rk_next[127:96] = rk_r[127:96] ^ t;
    rk_next[95:64]  = rk_r[95:64] ^ rk_next[127:96];
    rk_next[63:32]  = rk_r[63:32] ^ rk_next[95:64];
    rk_next[31:0]   = rk_r[31:0] ^ rk_next[63:32];
  end

  function automatic out_item_t make_tag(input logic [127:0] v, input logic [4:0] tl);
    out_item_t o;
    logic [127:0] m;
    m = '0;
    o = '0;
    if (!tag_len_ok(tl)) begin
      o.status = StatusTagLen;
    end else begin
      for (int i = 0; i < 16; i++) m[127-8*i -: 8] = (5'(i) < tl) ? 8'hff : 8'h00;
      o.status   = StatusOk;
      o.tag_high = v[127:64] & m[127:64];
      o.tag_low  = v[63:0] & m[63:0];
    end
    return o;
  endfunction

  always_comb begin
    chain_nxt = chain_r;
    st_nxt    = st_r;
    rk_nxt    = rk_r;
    rcon_nxt  = rcon_r;
    round_nxt = round_r;
    busy_nxt  = busy_r;
    last_nxt  = last_r;
    ov_nxt    = ov_r && out_stall;
    od_nxt    = od_r;
    if (busy_r) begin
      st_nxt   = ((round_r == 4'd10) ? sb : mc) ^ rk_next;
      rk_nxt   = rk_next;
      rcon_nxt = xt(rcon_r);
      round_nxt = round_r + 4'd1;
      if (round_r == 4'd10) begin
        chain_nxt = st_nxt;
        if (last_r) begin
          if (out_free) begin
            busy_nxt = 1'b0;
            ov_nxt   = 1'b1;
            od_nxt   = make_tag(st_nxt, tag_len);
          end else begin
            // Hold the final round until the result register frees up.
            st_nxt    = st_r;
            rk_nxt    = rk_r;
            rcon_nxt  = rcon_r;
            round_nxt = round_r;
            chain_nxt = chain_r;
          end
        end else begin
          busy_nxt = 1'b0;
        end
      end
    end else if (cmd_take) begin
      unique case (cmd.op)
        CMD_CLEAR: chain_nxt = '0;
        CMD_BLOCK: begin
          st_nxt    = chain_r ^ cmd.blk ^ {key_high, key_low};
          rk_nxt    = {key_high, key_low};
          rcon_nxt  = 8'h01;
          round_nxt = 4'd1;
          busy_nxt  = 1'b1;
          last_nxt  = cmd.last;
        end
        CMD_EMIT: begin
          ov_nxt = 1'b1;
          od_nxt = '{status: cmd.status, tag_high: '0, tag_low: '0};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      ov_r    <= 1'b0;
      chain_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      ov_r    <= ov_nxt;
      chain_r <= chain_nxt;
    end
    st_r    <= st_nxt;
    rk_r    <= rk_nxt;
    rcon_r  <= rcon_nxt;
    round_r <= round_nxt;
    last_r  <= last_nxt;
    od_r    <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule
